// ===== design/fkbt_pkg.sv =====
// ----------------------------------------------------------------------------
// fkbt_pkg
// Shared constants and types of the fixed-length byte-key trie map.
// ----------------------------------------------------------------------------
`default_nettype none

package fkbt_pkg;

    localparam int NODE_COUNT_DEF = 4096;
    localparam int KEY_BYTES_DEF  = 8;
    localparam int VALUE_BITS_DEF = 32;

    localparam int FANOUT      = 256;
    localparam int BYTE_BITS   = 8;
    localparam int KEY_WIDTH   = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int LEN_BITS    = 4;
    localparam int LVL_BITS    = 3;
    localparam int STATUS_BITS = 2;

    localparam logic [LEN_BITS-1:0] KEY_LENGTH_RST = 4'd8;

    typedef logic [STATUS_BITS-1:0] status_t;

    localparam status_t STATUS_OK   = 2'd0;
    localparam status_t STATUS_MISS = 2'd1;
    localparam status_t STATUS_FULL = 2'd2;

endpackage

`default_nettype wire

// ===== design/fkbt_slot_ram.sv =====
// ----------------------------------------------------------------------------
// fkbt_slot_ram
// Child-slot memory: one write port, one registered read port, with
// forwarding of a write to a read of the same entry in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fkbt_slot_ram #(
    parameter int DEPTH     = fkbt_pkg::NODE_COUNT_DEF * fkbt_pkg::FANOUT,
    parameter int DATA_BITS = fkbt_pkg::VALUE_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0]     wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_BITS-1:0]     rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] mem_q_reg;
    logic [DATA_BITS-1:0] fwd_data_reg;
    logic                 fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : mem_q_reg;

endmodule

`default_nettype wire

// ===== design/fixed_key_byte_trie_map.sv =====
// ----------------------------------------------------------------------------
// fixed_key_byte_trie_map
// Map of fixed-length byte keys to values, held in a 256-way trie in one
// slot memory with a bump allocator for nodes.
//
// Input channel (in_valid/in_ready): action, key, value. One result per
// transaction on the output channel (out_valid/out_ready): status and
// found_value. cfg_wr_en/cfg_wr_data set the key length; the user must
// do so only while idle, which the block itself does not enforce.
// The accept cycle reads the root's slot for the first key byte; then the
// walk steps down the key byte levels (a memory read per inner level; an
// insert may also write). The result is registered when the walk ends, and
// the next transaction is only taken after that, once the block is idle.
// A lookup that misses or an insert that runs out of nodes ends early.
// After reset the slot memory is cleared, one entry a cycle, over all
// NODE_COUNT*256 entries; in_ready stays low during that pass.
// A result waits in the output register while the next transaction is
// accepted; if it is still not taken, the walk holds at the level where it
// ends.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_key_byte_trie_map #(
    parameter int NODE_COUNT = fkbt_pkg::NODE_COUNT_DEF,
    parameter int KEY_BYTES  = fkbt_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BITS = fkbt_pkg::VALUE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                action,
    input  wire logic [fkbt_pkg::KEY_WIDTH-1:0]      key,
    input  wire logic [fkbt_pkg::DATA_WIDTH-1:0]     value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      [fkbt_pkg::STATUS_BITS-1:0]    status,
    output logic      [fkbt_pkg::DATA_WIDTH-1:0]     found_value,
    input  wire logic                                cfg_wr_en,
    input  wire logic [fkbt_pkg::LEN_BITS-1:0]       cfg_wr_data
);

    localparam int NODE_BITS  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int NF_BITS    = $clog2(NODE_COUNT + 1);
    localparam int SLOT_COUNT = NODE_COUNT * fkbt_pkg::FANOUT;
    localparam int ADDR_BITS  = $clog2(SLOT_COUNT);
    localparam int SLOT_BITS  = (VALUE_BITS > NODE_BITS) ? VALUE_BITS : NODE_BITS;
    localparam int LVL_BITS   = fkbt_pkg::LVL_BITS;
    localparam int LEN_BITS   = fkbt_pkg::LEN_BITS;
    localparam int BYTE_BITS  = fkbt_pkg::BYTE_BITS;
    localparam int OUT_BITS   = fkbt_pkg::DATA_WIDTH;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_WALK} state_t;

    state_t                         state_reg;
    logic [ADDR_BITS-1:0]           clr_addr_reg;
    logic [LEN_BITS-1:0]            key_length_reg;
    logic [NF_BITS-1:0]             next_free_reg;
    logic [LVL_BITS-1:0]            lvl_reg;
    logic [fkbt_pkg::KEY_WIDTH-1:0] key_reg;
    logic                           insert_reg;
    logic [OUT_BITS-1:0]            value_reg;
    logic [ADDR_BITS-1:0]           cur_addr_reg;
    logic                           out_valid_reg;
    fkbt_pkg::status_t              status_reg;
    logic [OUT_BITS-1:0]            found_reg;

    logic [LEN_BITS-1:0]  used_len;
    logic [LVL_BITS-1:0]  start_lvl;
    logic [LVL_BITS-1:0]  lvl_dec;
    logic [BYTE_BITS-1:0] in_byte;
    logic [BYTE_BITS-1:0] nxt_byte;
    logic                 accept;
    logic                 out_free;
    logic                 slot_empty;
    logic                 pool_full;
    logic [SLOT_BITS-1:0] leaf_value;
    logic [OUT_BITS-1:0]  found_calc;
    logic [NODE_BITS-1:0] child;

    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic [SLOT_BITS-1:0] rd_data;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [SLOT_BITS-1:0] wr_data;

    logic                 step_done;
    logic                 descend;
    logic                 alloc;
    fkbt_pkg::status_t    step_status;
    logic [OUT_BITS-1:0]  step_found;

    fkbt_slot_ram #(
        .DEPTH     (SLOT_COUNT),
        .DATA_BITS (SLOT_BITS)
    ) u_slot_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (key_length_reg == '0)
        begin
            used_len = LEN_BITS'(1);
        end
        else if (key_length_reg > LEN_BITS'(KEY_BYTES))
        begin
            used_len = LEN_BITS'(KEY_BYTES);
        end
        else
        begin
            used_len = key_length_reg;
        end
    end

    assign start_lvl  = LVL_BITS'(used_len - LEN_BITS'(1));
    assign lvl_dec    = lvl_reg - LVL_BITS'(1);
    assign in_byte    = key[{start_lvl, 3'b000} +: BYTE_BITS];
    assign nxt_byte   = key_reg[{lvl_dec, 3'b000} +: BYTE_BITS];
    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign slot_empty = (rd_data == '0) ||
                        ({1'b0, rd_data} >= (SLOT_BITS + 1)'(NODE_COUNT));
    assign pool_full  = (next_free_reg >= NF_BITS'(NODE_COUNT));
    assign leaf_value = SLOT_BITS'(VALUE_BITS'(value_reg) + VALUE_BITS'(1));
    assign found_calc = OUT_BITS'(rd_data - SLOT_BITS'(1));

    always_comb
    begin
        rd_en       = 1'b0;
        rd_addr     = cur_addr_reg;
        wr_en       = 1'b0;
        wr_addr     = cur_addr_reg;
        wr_data     = '0;
        step_done   = 1'b0;
        descend     = 1'b0;
        alloc       = 1'b0;
        step_status = fkbt_pkg::STATUS_OK;
        step_found  = '0;
        child       = rd_data[NODE_BITS-1:0];
        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ADDR_BITS'({{NODE_BITS{1'b0}}, in_byte});
                end
            end
            S_WALK:
            begin
                if (lvl_reg != '0)
                begin
                    if (slot_empty && !insert_reg)
                    begin
                        step_done   = 1'b1;
                        step_status = fkbt_pkg::STATUS_MISS;
                    end
                    else if (slot_empty && pool_full)
                    begin
                        step_done   = 1'b1;
                        step_status = fkbt_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        descend = 1'b1;
                        alloc   = slot_empty;
                        if (slot_empty)
                        begin
                            child = next_free_reg[NODE_BITS-1:0];
                        end
                        wr_en   = slot_empty;
                        wr_data = SLOT_BITS'(next_free_reg);
                        rd_en   = 1'b1;
                        rd_addr = ADDR_BITS'({child, nxt_byte});
                    end
                end
                else
                begin
                    step_done = 1'b1;
                    if (insert_reg)
                    begin
                        wr_en   = out_free;
                        wr_data = leaf_value;
                    end
                    else if (rd_data == '0)
                    begin
                        step_status = fkbt_pkg::STATUS_MISS;
                    end
                    else
                    begin
                        step_found = found_calc;
                    end
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            key_length_reg <= fkbt_pkg::KEY_LENGTH_RST;
            next_free_reg  <= NF_BITS'(1);
            lvl_reg        <= '0;
            key_reg        <= '0;
            insert_reg     <= 1'b0;
            value_reg      <= '0;
            cur_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= fkbt_pkg::STATUS_OK;
            found_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                key_length_reg <= cfg_wr_data;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_BITS'(1);
                    if (clr_addr_reg == ADDR_BITS'(SLOT_COUNT - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        key_reg      <= key;
                        insert_reg   <= action;
                        value_reg    <= value;
                        lvl_reg      <= start_lvl;
                        cur_addr_reg <= rd_addr;
                        state_reg    <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (descend)
                    begin
                        lvl_reg      <= lvl_dec;
                        cur_addr_reg <= rd_addr;
                        if (alloc)
                        begin
                            next_free_reg <= next_free_reg + NF_BITS'(1);
                        end
                    end
                    else if (step_done && out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= step_status;
                        found_reg     <= step_found;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_value = found_reg;

    // allocator only moves forward by one node
    a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg != $past(next_free_reg)) |->
        (next_free_reg == NF_BITS'($past(next_free_reg) + NF_BITS'(1))))
        else $error("allocator skipped a node");

    a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg <= NF_BITS'(NODE_COUNT)) && (next_free_reg != '0))
        else $error("allocator out of range");

    // inner-level writes only link new nodes into empty slots
    a_inner_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && wr_en && lvl_reg != '0) |-> slot_empty)
        else $error("live child slot overwritten");

    a_descend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && rd_en) |=>
        (lvl_reg == LVL_BITS'($past(lvl_reg) - LVL_BITS'(1))))
        else $error("walk level did not step down");

    a_result_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(status_reg) && $stable(found_reg))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== dv/fkbt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkbt_checker
// Watches the request, result and key-length ports of the byte trie map.
// Keeps its own copy of the slot memory, node allocator and key length, and
// predicts every result from the accepted request transactions. Each result
// is compared field by field with the oldest prediction. Unexpected results
// and wrong fields are counted as mismatches.
// ----------------------------------------------------------------------------

module fkbt_checker
    import fkbt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic                      action,
    input  logic [KEY_WIDTH-1:0]      key,
    input  logic [DATA_WIDTH-1:0]     value,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [STATUS_BITS-1:0]    status,
    input  logic [DATA_WIDTH-1:0]     found_value,
    input  logic                      cfg_wr_en,
    input  logic [LEN_BITS-1:0]       cfg_wr_data,
    output int                        mismatches,
    output int                        awaiting
);

    localparam int unsigned NODES = NODE_COUNT_DEF;

    typedef struct packed {
        status_t                 status;
        logic [DATA_WIDTH-1:0]   found;
    } answer_t;

    answer_t                 pending_answers[$];
    logic [DATA_WIDTH-1:0]   slot_mem[int unsigned];
    int unsigned             next_node;
    logic [LEN_BITS-1:0]     key_len;

    function automatic logic [DATA_WIDTH-1:0] slot_at(input int unsigned addr);
        return slot_mem.exists(addr) ? slot_mem[addr] : '0;
    endfunction

    function automatic answer_t walk_trie(input logic ins, input logic [KEY_WIDTH-1:0] k,
                                          input logic [DATA_WIDTH-1:0] v);
        int unsigned             depth;
        int unsigned             level;
        int unsigned             node;
        int unsigned             addr;
        logic [DATA_WIDTH-1:0]   child;
        answer_t                 ans;
        depth = (key_len == 0) ? 1 : ((key_len > KEY_BYTES_DEF) ? KEY_BYTES_DEF : key_len);
        ans.status = STATUS_OK;
        ans.found = '0;
        node = 0;
        level = depth;
        while (level > 1)
        begin
            level--;
            addr = node * FANOUT + k[BYTE_BITS*level +: BYTE_BITS];
            child = slot_at(addr);
            if (child == 0 || child >= NODES)
            begin
                if (!ins)
                begin
                    ans.status = STATUS_MISS;
                    break;
                end
                if (next_node >= NODES)
                begin
                    ans.status = STATUS_FULL;
                    break;
                end
                child = next_node;
                next_node++;
                slot_mem[addr] = child;
            end
            node = child;
        end
        if (ans.status == STATUS_OK)
        begin
            addr = node * FANOUT + k[BYTE_BITS-1:0];
            if (ins)
                slot_mem[addr] = v + 1'b1;
            else if (slot_at(addr) == 0)
                ans.status = STATUS_MISS;
            else
                ans.found = slot_at(addr) - 1'b1;
        end
        return ans;
    endfunction

    function automatic void report(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            slot_mem.delete();
            pending_answers.delete();
            next_node = 1;
            key_len = KEY_LENGTH_RST;
            mismatches = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_answers.size() == 0)
                    report($sformatf("unexpected result: status %0d found_value %h",
                                     status, found_value));
                else
                begin
                    want = pending_answers.pop_front();
                    if (status !== want.status)
                        report($sformatf("status: expected %0d, actual %0d",
                                         want.status, status));
                    if (found_value !== want.found)
                        report($sformatf("found_value: expected %h, actual %h",
                                         want.found, found_value));
                end
            end
            if (in_valid && in_ready)
                pending_answers.push_back(walk_trie(action, key, value));
            if (cfg_wr_en)
                key_len = cfg_wr_data;
        end
        awaiting = pending_answers.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the byte trie map: a short directed run of inserts and
// lookups at the reset key length, then random phases over several key
// lengths, one of them biased to exhaust the node pool. Both channels idle
// at random; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------

module testbench;

    import fkbt_pkg::*;

    localparam int LIMIT = 6_000_000;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic                      action;
    logic [KEY_WIDTH-1:0]      key;
    logic [DATA_WIDTH-1:0]     value;
    logic                      out_valid;
    logic                      out_ready;
    logic [STATUS_BITS-1:0]    status;
    logic [DATA_WIDTH-1:0]     found_value;
    logic                      cfg_wr_en;
    logic [LEN_BITS-1:0]       cfg_wr_data;
    int                        mismatches;
    int                        awaiting;

    int                        items_accepted = 0;
    int                        results_taken = 0;
    int                        cycle_count = 0;
    bit                        send_quiet = 1'b0;
    int                        send_switch = 0;
    logic [KEY_WIDTH-1:0]      known_keys[$];

    always #2 clk = ~clk;

    fixed_key_byte_trie_map dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found_value (found_value),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    fkbt_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found_value (found_value),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .awaiting    (awaiting)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stalls with quiet stretches
    initial
    begin : result_sink
        int gap;
        int until_switch;
        bit quiet;
        quiet = 1'b0;
        until_switch = 0;
        @(posedge clk);
        forever
        begin
            if (until_switch == 0)
            begin
                quiet = ($urandom_range(0, 3) == 0);
                until_switch = $urandom_range(8, 40);
            end
            until_switch--;
            gap = quiet ? 0 : $urandom_range(0, 17);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            results_taken++;
        end
    end

    task automatic send_item(input logic act, input logic [KEY_WIDTH-1:0] k,
                             input logic [DATA_WIDTH-1:0] v);
        int gap;
        if (send_switch == 0)
        begin
            send_quiet = ($urandom_range(0, 3) == 0);
            send_switch = $urandom_range(8, 40);
        end
        send_switch--;
        gap = send_quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        key <= k;
        value <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_accepted++;
        if (act)
        begin
            known_keys.push_back(k);
            if (known_keys.size() > 64)
                void'(known_keys.pop_front());
        end
    endtask

    // hold off new requests until every result is back
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_taken != items_accepted);
    endtask

    task automatic write_key_length(input logic [LEN_BITS-1:0] len);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [DATA_WIDTH-1:0] draw_value();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else if (r == 2)
            return 32'hFFFF_FFFE;
        else if (r < 6)
            return $urandom_range(1, 4095);
        return $urandom;
    endfunction

    task automatic run_phase(input logic [LEN_BITS-1:0] len, input int count, input bit fill);
        int                   r;
        logic [KEY_WIDTH-1:0] fresh;
        logic [KEY_WIDTH-1:0] pick;
        logic [KEY_WIDTH-1:0] near;
        logic [KEY_WIDTH-1:0] mask;
        write_key_length(len);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 63) == 0)
                settle();
            r = $urandom_range(0, 99);
            fresh = {$urandom, $urandom};
            pick = known_keys[$urandom_range(0, known_keys.size() - 1)];
            mask = (64'd1 << (BYTE_BITS * $urandom_range(1, 8))) - 64'd1;
            near = (pick & ~mask) | (fresh & mask);
            if (fill)
            begin
                if (r < 92)
                    send_item(1'b1, fresh, draw_value());
                else if (r < 97)
                    send_item(1'b0, pick, draw_value());
                else
                    send_item(1'b0, fresh, draw_value());
            end
            else if (r < 25)
                send_item(1'b1, fresh, draw_value());
            else if (r < 40)
                send_item(1'b1, near, draw_value());
            else if (r < 55)
                send_item(1'b1, pick, draw_value());
            else if (r < 85)
                send_item(1'b0, pick, draw_value());
            else if (r < 95)
                send_item(1'b0, near, draw_value());
            else
                send_item(1'b0, fresh, draw_value());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = 1'b0;
        key = '0;
        value = '0;
        out_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed transactions at the reset key length
        send_item(1'b0, 64'h0, 32'h0);
        send_item(1'b1, 64'h0, 32'h0);
        send_item(1'b0, 64'h0, 32'hFFFF_FFFF);
        send_item(1'b1, '1, 32'hFFFF_FFFE);
        send_item(1'b0, '1, 32'h0);
        send_item(1'b1, 64'h0, 32'hFFFF_FFFF);
        send_item(1'b0, 64'h0, 32'h0);
        send_item(1'b1, 64'h0123_4567_89AB_CDEF, 32'd5);
        send_item(1'b0, 64'h0123_4567_89AB_CDEF, 32'h0);
        send_item(1'b1, 64'h0123_4567_89AB_CDEF, 32'd7);
        send_item(1'b0, 64'h0123_4567_89AB_CDEF, 32'h0);
        send_item(1'b0, 64'h0123_4567_89AB_CDEE, 32'h0);
        send_item(1'b0, 64'h8123_4567_89AB_CDEF, 32'h0);
        send_item(1'b1, 64'h0123_4567_0000_0000, 32'hA5A5_5A5A);
        send_item(1'b0, 64'h0123_4567_0000_0000, 32'h0);
        send_item(1'b1, 64'hFFFF_FFFF_FFFF_FF00, 32'd1);
        send_item(1'b0, '1, 32'h0);
        send_item(1'b0, 64'hFFFF_FFFF_FFFF_FF00, 32'h5A5A_A5A5);

        run_phase(4'd1, 150, 1'b0);
        run_phase(4'd0, 100, 1'b0);
        run_phase(4'd3, 200, 1'b0);
        run_phase(4'd15, 800, 1'b1);
        run_phase(4'd2, 200, 1'b0);
        run_phase(4'd8, 200, 1'b0);
        run_phase(4'd5, 150, 1'b0);
        run_phase(4'd9, 150, 1'b0);

        settle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && awaiting == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
